>>> hw/rtl/lcr_pkg.sv
package lcr_pkg;

	localparam int ADC_BITS  = 24;
	localparam int SUM_BITS  = 40;
	localparam int DIV_STEPS = SUM_BITS;
	localparam int DCNT_BITS = $clog2(DIV_STEPS);

	localparam logic [ADC_BITS-1:0] SIGN_FLIP = 24'h800000;

	// action codes
	localparam logic [1:0] ACT_NONE  = 2'd0;
	localparam logic [1:0] ACT_WEIGH = 2'd1;
	localparam logic [1:0] ACT_TARE  = 2'd2;
	localparam logic [1:0] ACT_AVG   = 2'd3;

	// register indexes
	localparam logic [1:0] REG_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_GAP     = 2'd1;
	localparam logic [1:0] REG_SCALE   = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE, PH_WAIT, PH_HIGH, PH_LOW, PH_XHIGH, PH_XLOW, PH_GAP
	} phase_t;

	typedef enum logic [2:0] {
		CS_TICK, CS_MUL, CS_ACC, CS_DIV, CS_FIN
	} ctl_state_t;

	// what a tick or an accumulate step leads to
	typedef enum logic [1:0] {
		K_PLAIN, K_SAMPLE, K_DIV
	} kind_t;

	typedef struct packed {
		logic tick;
		logic mul;
		logic acc;
		logic div;
		logic fin;
		logic load;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  div_last;
	} sts_t;

endpackage

>>> hw/rtl/lcr_in_if.sv
interface lcr_in_if;
	import lcr_pkg::*;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] sample_count;
	logic       data_pin;

	modport source (output valid, action, sample_count, data_pin, input ready);
	modport sink (input valid, action, sample_count, data_pin, output ready);
endinterface

>>> hw/rtl/lcr_out_if.sv
interface lcr_out_if;
	logic        valid;
	logic        ready;
	logic        clock_pin;
	logic        busy_res;
	logic        done_res;
	logic        status;
	logic [31:0] weight;
	logic [23:0] tare_value;

	modport source (output valid, clock_pin, busy_res, done_res, status, weight, tare_value,
		input ready);
	modport sink (input valid, clock_pin, busy_res, done_res, status, weight, tare_value,
		output ready);
endinterface

>>> hw/rtl/lcr_ctrl.sv
module lcr_ctrl import lcr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic out_ready,
	output logic out_valid,
	input  sts_t sts,
	output cmd_t cmd
);

	ctl_state_t state_q, state_nxt;
	logic       ovalid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			CS_TICK: begin
				if (cmd.tick) begin
					case (sts.kind)
						K_SAMPLE: state_nxt = CS_MUL;
						K_DIV:    state_nxt = CS_DIV;
						default:  state_nxt = CS_TICK;
					endcase
				end
			end
			CS_MUL: state_nxt = CS_ACC;
			CS_ACC: state_nxt = (sts.kind == K_DIV) ? CS_DIV : CS_TICK;
			CS_DIV: if (sts.div_last) state_nxt = CS_FIN;
			CS_FIN: state_nxt = CS_TICK;
			default: state_nxt = CS_TICK;
		endcase
	end

	always_comb begin
		in_ready = (state_q == CS_TICK) && (!ovalid_q || out_ready);
		cmd.tick = in_ready && in_valid;
		cmd.mul  = (state_q == CS_MUL);
		cmd.acc  = (state_q == CS_ACC);
		cmd.div  = (state_q == CS_DIV);
		cmd.fin  = (state_q == CS_FIN);
		cmd.load = ((cmd.tick || cmd.acc) && sts.kind == K_PLAIN) || cmd.fin;
	end

	assign out_valid = ovalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= CS_TICK;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load)
				ovalid_q <= 1'b1;
			else if (out_ready)
				ovalid_q <= 1'b0;
		end
	end

endmodule

>>> hw/rtl/lcr_dp.sv
module lcr_dp import lcr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [1:0]  action,
	input  logic [7:0]  sample_count,
	input  logic        data_pin,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output logic        clock_pin,
	output logic        busy_res,
	output logic        done_res,
	output logic        status,
	output logic [31:0] weight,
	output logic [23:0] tare_value
);

	logic [23:0] timeout_q, gap_q, scale_q;

	phase_t                phase_q, n_phase;
	logic [1:0]            op_q, n_op;
	logic [4:0]            bit_q, n_bit;
	logic [ADC_BITS-1:0]   shift_q, n_shift;
	logic [23:0]           wait_q, n_wait;
	logic [7:0]            left_q, n_left;
	logic [7:0]            valid_q, n_valid;
	logic [SUM_BITS-1:0]   sum_q, n_sum;
	logic [23:0]           tare_q, n_tare;
	logic [31:0]           weight_q, n_weight;
	logic [7:0]            rem_q, n_rem;
	logic [DCNT_BITS-1:0]  dcnt_q, n_dcnt;
	logic [47:0]           prod_s1;

	logic        r_clk, r_done, r_status;
	kind_t       kind;
	logic [23:0] raw;
	logic [31:0] term;
	logic [8:0]  trial;
	logic        ge;
	logic        finish;

	assign raw = shift_q ^ SIGN_FLIP;
	assign trial = {rem_q, sum_q[SUM_BITS-1]};
	assign ge = trial >= {1'b0, valid_q};

	always_comb begin
		n_phase  = phase_q;
		n_op     = op_q;
		n_bit    = bit_q;
		n_shift  = shift_q;
		n_wait   = wait_q;
		n_left   = left_q;
		n_valid  = valid_q;
		n_sum    = sum_q;
		n_tare   = tare_q;
		n_weight = weight_q;
		n_rem    = rem_q;
		n_dcnt   = dcnt_q;
		r_clk    = 1'b0;
		r_done   = 1'b0;
		r_status = 1'b0;
		kind     = K_PLAIN;
		term     = '0;
		finish   = 1'b0;

		if (cmd.acc) begin
			if (raw != '0) begin
				if (op_q == ACT_TARE)
					term = {8'd0, raw};
				else if (raw > tare_q)
					term = prod_s1[47:16];
				n_sum   = sum_q + {8'd0, term};
				n_valid = valid_q + 8'd1;
			end
			n_left = left_q - 8'd1;
			if (op_q != ACT_WEIGH && gap_q != '0) begin
				n_phase = PH_GAP;
				n_wait  = '0;
			end else if (n_left == '0) begin
				finish = 1'b1;
			end else begin
				n_phase = PH_WAIT;
				n_wait  = '0;
			end
		end else if (cmd.div) begin
			n_rem  = ge ? 8'(trial - {1'b0, valid_q}) : trial[7:0];
			n_sum  = {sum_q[SUM_BITS-2:0], ge};
			n_dcnt = dcnt_q + 1'b1;
		end else if (cmd.fin) begin
			if (op_q == ACT_TARE)
				n_tare = sum_q[23:0];
			else
				n_weight = sum_q[31:0];
			r_done = 1'b1;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (action != ACT_NONE) begin
						n_op    = action;
						n_left  = (action == ACT_WEIGH || sample_count == '0) ? 8'd1
							: sample_count;
						n_valid = '0;
						n_sum   = '0;
						n_wait  = '0;
						n_phase = PH_WAIT;
					end
				end
				PH_WAIT: begin
					if (!data_pin) begin
						n_bit   = '0;
						n_shift = '0;
						n_phase = PH_HIGH;
					end else begin
						n_wait = wait_q + 24'd1;
						if (n_wait >= timeout_q) begin
							n_shift = SIGN_FLIP;  // raw zero: invalid sample
							kind    = K_SAMPLE;
						end
					end
				end
				PH_HIGH: begin
					r_clk   = 1'b1;
					n_phase = PH_LOW;
				end
				PH_LOW: begin
					n_shift = {shift_q[ADC_BITS-2:0], data_pin};
					n_bit   = bit_q + 5'd1;
					n_phase = (n_bit >= 5'(ADC_BITS)) ? PH_XHIGH : PH_HIGH;
				end
				PH_XHIGH: begin
					r_clk   = 1'b1;
					n_phase = PH_XLOW;
				end
				PH_XLOW: kind = K_SAMPLE;
				PH_GAP: begin
					n_wait = wait_q + 24'd1;
					if (n_wait >= gap_q) begin
						if (left_q == '0) begin
							finish = 1'b1;
						end else begin
							n_phase = PH_WAIT;
							n_wait  = '0;
						end
					end
				end
				default: n_phase = PH_IDLE;
			endcase
		end

		if (finish) begin
			n_phase = PH_IDLE;
			if (n_valid != '0) begin
				kind   = K_DIV;
				n_rem  = '0;
				n_dcnt = '0;
			end else begin
				r_done   = 1'b1;
				r_status = 1'b1;
			end
		end
	end

	assign sts.kind     = kind;
	assign sts.div_last = (dcnt_q == DCNT_BITS'(DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= 24'd100000;
			gap_q     <= 24'd1000;
			scale_q   <= 24'd65536;
			phase_q   <= PH_IDLE;
			op_q      <= '0;
			bit_q     <= '0;
			shift_q   <= '0;
			wait_q    <= '0;
			left_q    <= '0;
			valid_q   <= '0;
			sum_q     <= '0;
			tare_q    <= '0;
			weight_q  <= '0;
			rem_q     <= '0;
			dcnt_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TIMEOUT: timeout_q <= cfg_data;
					REG_GAP:     gap_q     <= cfg_data;
					REG_SCALE:   scale_q   <= cfg_data;
					default:     ;
				endcase
			end
			if (cmd.tick || cmd.acc || cmd.div || cmd.fin) begin
				phase_q  <= n_phase;
				op_q     <= n_op;
				bit_q    <= n_bit;
				shift_q  <= n_shift;
				wait_q   <= n_wait;
				left_q   <= n_left;
				valid_q  <= n_valid;
				sum_q    <= n_sum;
				tare_q   <= n_tare;
				weight_q <= n_weight;
				rem_q    <= n_rem;
				dcnt_q   <= n_dcnt;
			end
		end
	end

	// product and result beat: payload only
	always_ff @(posedge clk) begin
		if (cmd.mul)
			prod_s1 <= 48'(raw - tare_q) * 48'(scale_q);
		if (cmd.load) begin
			clock_pin  <= r_clk;
			busy_res   <= (n_phase != PH_IDLE);
			done_res   <= r_done;
			status     <= r_status;
			weight     <= n_weight;
			tare_value <= n_tare;
		end
	end

endmodule

>>> hw/rtl/load_cell_adc_reader_with_tare.sv
// Channel | Dir | Payload                                              | Beat
// in_ch   | in  | action[1:0], sample_count[7:0], data_pin             | one sensor tick
// out_ch  | out | clock_pin, busy_res, done_res, status, weight[31:0], | one per tick
//         |     | tare_value[23:0]                                     |
// cfg     | in  | cfg_we, cfg_index[1:0], cfg_data[23:0]               | register write
//
// Most ticks have their result registered on the accepting edge.
// The tick ending a sample also passes the product register and accumulate.
// A tick ending an operation with valid samples also divides: the mean
// comes from a restoring divider, one quotient bit a cycle over the 40-bit sum.
// A stalled out_ch holds its beat; in_ch is taken while that beat leaves.
// Reset (arst_n, async) clears the sequencer and loads register defaults.
module load_cell_adc_reader_with_tare import lcr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	lcr_in_if.sink      in_ch,
	lcr_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	// sequencing and output-beat valid
	lcr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	// serial state, accumulation, divider, stored tare/weight
	lcr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.action       (in_ch.action),
		.sample_count (in_ch.sample_count),
		.data_pin     (in_ch.data_pin),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.clock_pin    (out_ch.clock_pin),
		.busy_res     (out_ch.busy_res),
		.done_res     (out_ch.done_res),
		.status       (out_ch.status),
		.weight       (out_ch.weight),
		.tare_value   (out_ch.tare_value)
	);

endmodule

>>> hw/rtl/lcr_checker.sv
module lcr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        clock_pin,
	input logic        busy_res,
	input logic        done_res,
	input logic        status,
	input logic [31:0] weight
);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done beat shows busy");

	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> done_res)
		else $error("status set outside done beat");

	a_clk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clock_pin |-> busy_res && !done_res)
		else $error("clock pulse while idle");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(weight))
		else $error("stalled beat changed");

endmodule

bind load_cell_adc_reader_with_tare lcr_checker u_lcr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.clock_pin (out_ch.clock_pin),
	.busy_res  (out_ch.busy_res),
	.done_res  (out_ch.done_res),
	.status    (out_ch.status),
	.weight    (out_ch.weight)
);

>>> tb/load_cell_adc_reader_with_tare_tb.sv
module load_cell_adc_reader_with_tare_tb;
	import lcr_pkg::*;

	// one beat on out_ch, also used as the expectation record
	typedef struct {
		logic        clock_pin;
		logic        busy_res;
		logic        done_res;
		logic        status;
		logic [31:0] weight;
		logic [23:0] tare_value;
	} tick_res_t;

	// one measurement: what to start and how the emulated sensor answers.
	// fixed: every sample uses word/delay below; typed: completion is checked
	// against the hand-computed status/weight/tare instead of the predictor.
	typedef struct {
		logic [1:0]  act;
		logic [7:0]  cnt;
		logic [23:0] word;
		int unsigned delay;
		bit          fixed;
		bit          typed;
		logic        t_status;
		logic [31:0] t_weight;
		logic [23:0] t_tare;
	} meas_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [23:0] cfg_data;

	lcr_in_if  in_ch();
	lcr_out_if out_ch();

	load_cell_adc_reader_with_tare i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ---------------------------------------------------------------
	// Sequencer model: registers and state of the reader
	// ---------------------------------------------------------------
	logic [23:0] m_timeout, m_gap, m_scale;
	phase_t      m_ph;
	logic [1:0]  m_op;
	logic [4:0]  m_bit;
	logic [23:0] m_shift;
	logic [23:0] m_wcnt;
	logic [7:0]  m_left;
	logic [7:0]  m_nvalid;
	logic [39:0] m_sum;
	logic [23:0] m_tare;
	logic [31:0] m_weight;
	bit          m_fresh;   // a new sample wait began on this tick

	tick_res_t exp_q[$];
	meas_t     meas_q[$];
	meas_t     pend, run_meas;
	bit        pend_ok;
	int        rand_left;
	bit        only_weigh;
	bit        calm;

	// emulated sensor for the current sample
	logic [23:0] s_word;
	int unsigned s_delay, s_high;

	int errors, n_ticks, n_meas, n_done, n_bad;

	// store the mean and go idle
	task automatic close_meas();
		logic [39:0] mean;
		if (m_nvalid != 0) begin
			mean = m_sum / m_nvalid;
			if (m_op == ACT_TARE)
				m_tare = mean[23:0];
			else
				m_weight = mean[31:0];
		end
		m_ph = PH_IDLE;
	endtask

	task automatic next_sample(output bit done);
		done = 0;
		if (m_left == 0) begin
			close_meas();
			done = 1;
		end else begin
			m_ph    = PH_WAIT;
			m_wcnt  = '0;
			m_fresh = 1;
		end
	endtask

	task automatic finish_sample(input logic [23:0] raw, output bit done);
		logic [47:0] prod;
		logic [39:0] term;
		done = 0;
		if (raw != 0) begin
			if (m_op == ACT_TARE)
				term = {16'b0, raw};
			else if (raw > m_tare) begin
				prod = {24'b0, raw - m_tare} * {24'b0, m_scale};
				term = {8'b0, prod[47:16]};
			end else
				term = '0;
			m_sum    = m_sum + term;
			m_nvalid = m_nvalid + 8'd1;
		end
		m_left = m_left - 8'd1;
		if (m_op != ACT_WEIGH && m_gap != 0) begin
			m_ph   = PH_GAP;
			m_wcnt = '0;
		end else
			next_sample(done);
	endtask

	task automatic sensor_tick(input logic [1:0] act, input logic [7:0] cnt,
		input logic dp, output tick_res_t r);
		bit done;
		done    = 0;
		m_fresh = 0;
		r.clock_pin = 1'b0;
		case (m_ph)
			PH_IDLE: begin
				if (act != ACT_NONE) begin
					m_op     = act;
					m_left   = (act == ACT_WEIGH || cnt == 0) ? 8'd1 : cnt;
					m_nvalid = '0;
					m_sum    = '0;
					m_wcnt   = '0;
					m_ph     = PH_WAIT;
					m_fresh  = 1;
				end
			end
			PH_WAIT: begin
				if (!dp) begin
					m_bit   = '0;
					m_shift = '0;
					m_ph    = PH_HIGH;
				end else begin
					m_wcnt = m_wcnt + 24'd1;
					if (m_wcnt >= m_timeout)
						finish_sample('0, done);
				end
			end
			PH_HIGH: begin
				r.clock_pin = 1'b1;
				m_ph = PH_LOW;
			end
			PH_LOW: begin
				m_shift = {m_shift[22:0], dp};
				m_bit   = m_bit + 5'd1;
				m_ph    = (m_bit >= ADC_BITS) ? PH_XHIGH : PH_HIGH;
			end
			PH_XHIGH: begin
				r.clock_pin = 1'b1;
				m_ph = PH_XLOW;
			end
			PH_XLOW: finish_sample(m_shift ^ SIGN_FLIP, done);
			PH_GAP: begin
				m_wcnt = m_wcnt + 24'd1;
				if (m_wcnt >= m_gap)
					next_sample(done);
			end
			default: m_ph = PH_IDLE;
		endcase
		r.busy_res   = (m_ph != PH_IDLE);
		r.done_res   = done;
		r.status     = done && (m_nvalid == 0);
		r.weight     = m_weight;
		r.tare_value = m_tare;
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom % 16;
		if (r < 8)
			return 0;
		if (r < 14)
			return $urandom_range(1, 3);
		if (r == 14)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic meas_t random_meas();
		meas_t m;
		m = '{default: '0};
		m.act = only_weigh ? ACT_WEIGH : 2'($urandom_range(1, 3));
		// a longer averaging run now and then, only where the gap is short
		if (m_gap <= 3 && $urandom % 64 == 0)
			m.cnt = 8'($urandom_range(5, 8));
		else
			m.cnt = 8'($urandom % 5);
		return m;
	endfunction

	// ---------------------------------------------------------------
	// in_ch: one sensor tick per beat
	// ---------------------------------------------------------------
	int in_gap;

	always @(posedge clk or negedge arst_n) begin
		tick_res_t   r;
		logic [1:0]  act;
		logic [7:0]  cnt;
		logic        dp;
		bit          go;
		int          k;
		if (!arst_n) begin
			in_ch.valid        <= 1'b0;
			in_ch.action       <= ACT_NONE;
			in_ch.sample_count <= '0;
			in_ch.data_pin     <= 1'b1;
			in_gap = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				if (m_ph == PH_IDLE && in_ch.action != ACT_NONE) begin
					run_meas = pend;
					pend_ok  = 0;
					n_meas++;
				end
				if (m_ph == PH_WAIT && in_ch.data_pin)
					s_high++;
				sensor_tick(in_ch.action, in_ch.sample_count, in_ch.data_pin, r);
				if (r.done_res) begin
					n_done++;
					if (r.status)
						n_bad++;
					if (run_meas.typed) begin
						r.status     = run_meas.t_status;
						r.weight     = run_meas.t_weight;
						r.tare_value = run_meas.t_tare;
					end
				end
				exp_q.push_back(r);
				// pick the word and ready delay of the sample that starts now
				if (m_fresh) begin
					s_high = 0;
					if (run_meas.fixed) begin
						s_word  = run_meas.word;
						s_delay = run_meas.delay;
					end else begin
						k = $urandom % 8;
						if (k == 0)
							s_word = SIGN_FLIP;   // raw zero: invalid sample
						else if (k == 1)
							s_word = (m_tare + 24'($urandom_range(0, 4)) - 24'd2) ^ SIGN_FLIP;
						else
							s_word = 24'($urandom);
						if (m_timeout <= 64 && $urandom % 8 == 0)
							s_delay = m_timeout + $urandom_range(0, 2);
						else
							s_delay = $urandom % 4;
					end
				end
				n_ticks++;
				if (n_ticks % 400 == 0)
					calm = ($urandom % 3 == 0);
				in_gap = calm ? 0 : gap_len();
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (in_gap > 0) begin
					in_gap--;
					in_ch.valid <= 1'b0;
				end else begin
					go  = 1;
					dp  = 1'($urandom);
					act = 2'($urandom);
					cnt = 8'($urandom);
					case (m_ph)
						PH_IDLE: begin
							act = ACT_NONE;
							if (!pend_ok) begin
								if (meas_q.size() != 0) begin
									pend    = meas_q.pop_front();
									pend_ok = 1;
								end else if (rand_left > 0) begin
									pend    = random_meas();
									pend_ok = 1;
									rand_left--;
								end
							end
							if (!pend_ok)
								go = 0;
							else if ($urandom % 4 != 0) begin
								act = pend.act;
								cnt = pend.cnt;
							end
						end
						PH_WAIT: dp = (s_high >= s_delay) ? 1'b0 : 1'b1;
						PH_LOW:  dp = s_word[23 - m_bit];
						default: ;
					endcase
					in_ch.valid        <= go;
					in_ch.action       <= act;
					in_ch.sample_count <= cnt;
					in_ch.data_pin     <= dp;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// out_ch: compare each beat with the oldest expectation
	// ---------------------------------------------------------------
	int out_gap;

	always @(posedge clk or negedge arst_n) begin
		tick_res_t e;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			out_gap = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (exp_q.size() == 0) begin
					$error("out_ch beat with nothing expected");
					errors++;
				end else begin
					e = exp_q.pop_front();
					if (out_ch.clock_pin !== e.clock_pin) begin
						$error("clock_pin exp %0b got %0b", e.clock_pin, out_ch.clock_pin);
						errors++;
					end
					if (out_ch.busy_res !== e.busy_res) begin
						$error("busy_res exp %0b got %0b", e.busy_res, out_ch.busy_res);
						errors++;
					end
					if (out_ch.done_res !== e.done_res) begin
						$error("done_res exp %0b got %0b", e.done_res, out_ch.done_res);
						errors++;
					end
					if (out_ch.status !== e.status) begin
						$error("status exp %0b got %0b", e.status, out_ch.status);
						errors++;
					end
					if (out_ch.weight !== e.weight) begin
						$error("weight exp %h got %h", e.weight, out_ch.weight);
						errors++;
					end
					if (out_ch.tare_value !== e.tare_value) begin
						$error("tare_value exp %h got %h", e.tare_value, out_ch.tare_value);
						errors++;
					end
				end
				out_gap = calm ? 0 : gap_len();
			end
			if (out_gap > 0) begin
				out_gap--;
				out_ch.ready <= 1'b0;
			end else
				out_ch.ready <= 1'b1;
		end
	end

	// ---------------------------------------------------------------
	// Control
	// ---------------------------------------------------------------
	task automatic add_meas(input logic [1:0] act, input logic [7:0] cnt,
		input logic [23:0] word, input int unsigned delay, input bit typed,
		input logic st, input logic [31:0] w, input logic [23:0] t);
		meas_t m;
		m = '{act: act, cnt: cnt, word: word, delay: delay, fixed: 1'b1,
			typed: typed, t_status: st, t_weight: w, t_tare: t};
		meas_q.push_back(m);
	endtask

	// block idle and every beat seen; the divider may still be finishing
	task automatic drain();
		@(negedge clk);
		while (meas_q.size() != 0 || rand_left != 0 || pend_ok || m_ph != PH_IDLE
			|| exp_q.size() != 0)
			@(negedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [23:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TIMEOUT: m_timeout <= v;
			REG_GAP:     m_gap     <= v;
			default:     m_scale   <= v;
		endcase
	endtask

	task automatic random_phase(input logic [23:0] t, input logic [23:0] g,
		input logic [23:0] s, input int n, input bit weigh_only);
		write_reg(REG_TIMEOUT, t);
		write_reg(REG_GAP, g);
		write_reg(REG_SCALE, s);
		@(negedge clk);
		only_weigh = weigh_only;
		rand_left  = n;
		drain();
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_TIMEOUT;
		cfg_data  = '0;
		m_timeout = 24'd100000;
		m_gap     = 24'd1000;
		m_scale   = 24'd65536;
		m_ph      = PH_IDLE;
		m_op      = ACT_NONE;
		m_bit     = '0;
		m_shift   = '0;
		m_wcnt    = '0;
		m_left    = '0;
		m_nvalid  = '0;
		m_sum     = '0;
		m_tare    = '0;
		m_weight  = '0;
		pend_ok   = 0;
		rand_left = 0;
		only_weigh = 0;
		calm      = 0;
		run_meas  = '{default: '0};
		s_word    = '0;
		s_delay   = 0;
		s_high    = 0;
		errors    = 0;
		n_ticks   = 0;
		n_meas    = 0;
		n_done    = 0;
		n_bad     = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// short wait limit and gap keep the directed set brief
		write_reg(REG_TIMEOUT, 24'd30);
		write_reg(REG_GAP, 24'd2);

		// directed set: tare 0 and the unit reset scale make weight
		// equal raw, so most completions are typed in directly
		//        act        cnt    word       delay   typed st weight        tare
		add_meas(ACT_WEIGH, 8'd0,  24'hFFFFFF, 0,      1, 0, 32'h007FFFFF, 24'h000000);
		add_meas(ACT_WEIGH, 8'd9,  24'h800000, 2,      1, 1, 32'h007FFFFF, 24'h000000);
		add_meas(ACT_WEIGH, 8'd0,  24'h000000, 1,      1, 0, 32'h00800000, 24'h000000);
		add_meas(ACT_TARE,  8'd2,  24'h000001, 3,      1, 0, 32'h00800000, 24'h800001);
		add_meas(ACT_WEIGH, 8'd0,  24'h000000, 0,      1, 0, 32'h00000000, 24'h800001);
		add_meas(ACT_AVG,   8'd0,  24'hC35A17, 0,      0, 0, 32'h0,        24'h0);
		// data line never drops: the wait runs out
		add_meas(ACT_WEIGH, 8'd0,  24'h123456, 30,     1, 1, 32'h00000000, 24'h800001);
		add_meas(ACT_TARE,  8'd1,  24'h800000, 0,      1, 1, 32'h00000000, 24'h800001);
		add_meas(ACT_TARE,  8'd1,  24'h7FFFFF, 0,      1, 0, 32'h00000000, 24'hFFFFFF);
		add_meas(ACT_WEIGH, 8'd0,  24'hFFFFFF, 0,      1, 0, 32'h00000000, 24'hFFFFFF);
		add_meas(ACT_TARE,  8'd1,  24'h800001, 0,      1, 0, 32'h00000000, 24'h000001);
		add_meas(ACT_AVG,   8'd2,  24'h000000, 2,      1, 0, 32'h007FFFFF, 24'h000001);
		add_meas(ACT_AVG,   8'd3,  24'h5A5A5A, 1,      0, 0, 32'h0,        24'h0);
		add_meas(ACT_WEIGH, 8'd0,  24'hA5A5A5, 0,      0, 0, 32'h0,        24'h0);
		drain();

		// smallest timeout, no gap, smallest scale
		random_phase(24'd1, 24'd0, 24'd1, 2, 0);
		// largest timeout and scale
		random_phase(24'hFFFFFF, 24'd0, 24'hFFFFFF, 2, 0);
		// short timeout with gaps, longer averaging runs possible
		random_phase(24'd7, 24'd3, 24'd65536, 2, 0);
		// longest gap: single weighings only, which insert no gap
		random_phase(24'd20, 24'hFFFFFF, 24'd300, 2, 1);
		random_phase(24'd12, 24'd1, 24'd4321, 2, 0);

		$display("Covered %0d sensor ticks, %0d measurements started, %0d completed",
			n_ticks, n_meas, n_done);
		$display("(%0d with no valid sample) over six register settings", n_bad);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#100000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
